// ----- sv/prqm_pkg.sv -----
// shared types and constants for the priority ring queue manager
package prqm_pkg;

   localparam int NUM_QUEUES = 16;
   localparam int NUM_LEVELS = 4;
   localparam int RING_DEPTH = 64;

   localparam int FUNC_W = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 7;
   localparam int LIU_W = 3;
   localparam int CAP_W = 7;
   localparam int HOFS_W = 12;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_LEVELS = 2'd0,
      REG_CAP    = 2'd1,
      REG_HOFS   = 2'd2
   } reg_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_NORM,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

endpackage

// ----- sv/prqm_if.sv -----
// valid/ready channel interfaces for requests and responses
interface prqm_req_if #(parameter int VALUE_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [1:0]             func;
   logic [3:0]             queue_id;
   logic [1:0]             level;
   logic                   urgent;
   logic [VALUE_WIDTH-1:0] value;
   modport source (output valid, func, queue_id, level, urgent, value, input ready);
   modport sink (input valid, func, queue_id, level, urgent, value, output ready);
endinterface

interface prqm_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [VALUE_WIDTH-1:0] value_out;
   logic [1:0]             served_level;
   logic [6:0]             occupancy;
   modport source (output valid, status, value_out, served_level, occupancy, input ready);
   modport sink (input valid, status, value_out, served_level, occupancy, output ready);
endinterface

// ----- sv/priority_ring_queue_manager_core.sv -----
// top level of the priority ring queue manager
// Usage: request transactions enter on req (func, queue_id, level, urgent,
// value); exactly one response transaction leaves on rsp per request.
// Registers levels_in_use, ring_capacity and head_offset are written on the csr
// APB port at byte addresses 0, 4 and 8; the user must do so only while the block
// is idle; the block does not enforce it. One request is processed at a time.
// Per-ring descriptors (head, tail, count, urgent count for all levels of a
// queue) sit in a descriptor memory, one row per queue, ring contents in a store
// memory; both are synchronous with a registered read.
// Query, normal push and pop pass through read, decide/write and done before
// the response is registered; the next request is accepted only once the FSM
// is back in idle. When the ring index in use is at or above the current
// capacity (only after ring_capacity is lowered) a restoring reduction in the
// norm state brings it into range first. An urgent push adds a store read then
// write per urgent entry moved, at most ring capacity-1, and a final write step.
// After reset the descriptor memory is cleared one row per cycle, over all
// NUM_QUEUES rows; req.ready stays low meanwhile.
// The response sits in an output register; while rsp is stalled the next
// request is accepted and processed, then waits until the register frees.
module priority_ring_queue_manager_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   prqm_req_if.sink             req,
   prqm_rsp_if.source           rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import prqm_pkg::*;

   localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PW  = $clog2(RING_DEPTH);
   localparam int CW  = $clog2(RING_DEPTH + 1);
   localparam int SAW = QW + LW + PW;
   localparam int NLW = $clog2(NUM_LEVELS + 1);
   localparam int SHW = $clog2(PW);
   localparam int NDW = CW + PW;

   typedef struct packed {
      logic [PW-1:0] head;
      logic [PW-1:0] tail;
      logic [CW-1:0] cnt;
      logic [CW-1:0] urg;
   } desc_type;

   // configuration
   logic [LIU_W-1:0]  liu_ff;
   logic [CAP_W-1:0]  cap_reg_ff;
   logic [HOFS_W-1:0] hofs_ff;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         liu_ff     <= LIU_W'(1);
         cap_reg_ff <= CAP_W'(64);
         hofs_ff    <= '0;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_LEVELS: liu_ff <= csr_pwdata[LIU_W-1:0];
            REG_CAP:    cap_reg_ff <= csr_pwdata[CAP_W-1:0];
            REG_HOFS:   hofs_ff <= csr_pwdata[HOFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         REG_LEVELS: csr_prdata = 32'(liu_ff);
         REG_CAP:    csr_prdata = 32'(cap_reg_ff);
         REG_HOFS:   csr_prdata = 32'(hofs_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // effective capacity and level count
   logic [CW-1:0]  cap;
   logic [NLW-1:0] nlev;
   always_comb begin
      if (cap_reg_ff == '0) cap = CW'(1);
      else if (32'(cap_reg_ff) > RING_DEPTH) cap = CW'(RING_DEPTH);
      else cap = CW'(cap_reg_ff);
      if (32'(liu_ff) > NUM_LEVELS) nlev = NLW'(NUM_LEVELS);
      else nlev = NLW'(liu_ff);
   end

   // memories
   desc_type                desc_mem [NUM_QUEUES][NUM_LEVELS];
   desc_type                desc_rd_ff [NUM_LEVELS];
   logic [VALUE_WIDTH-1:0]  store_mem [NUM_QUEUES*NUM_LEVELS*RING_DEPTH];
   logic [VALUE_WIDTH-1:0]  store_rd_ff;

   logic                    d_we;
   logic [QW-1:0]           d_waddr;
   desc_type                d_wrow [NUM_LEVELS];
   logic [QW-1:0]           d_raddr;
   logic                    s_we;
   logic [SAW-1:0]          s_waddr;
   logic [VALUE_WIDTH-1:0]  s_wdata;
   logic                    s_re;
   logic [SAW-1:0]          s_raddr;

   always_ff @(posedge clock) begin
      if (d_we) begin
         for (int l = 0; l < NUM_LEVELS; l++) desc_mem[d_waddr][l] <= d_wrow[l];
      end
      for (int l = 0; l < NUM_LEVELS; l++) desc_rd_ff[l] <= desc_mem[d_raddr][l];
   end

   always_ff @(posedge clock) begin
      if (s_we) store_mem[s_waddr] <= s_wdata;
      if (s_re) store_rd_ff <= store_mem[s_raddr];
   end

   // control
   state_type              state_ff, state_in;
   logic [QW-1:0]          clr_ff, clr_in;
   func_type               func_ff;
   logic [QW-1:0]          q_ff;
   logic [LW-1:0]          lvl_ff, lvl_in;
   logic                   urg_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   desc_type               cur_ff, cur_in;
   logic [CW-1:0]          k_ff, k_in, u_ff, u_in;
   logic [PW-1:0]          nh_ff, nh_in;
   logic [STATUS_W-1:0]    st_ff, st_in;
   logic                   pop_ff, pop_in;
   logic [PW-1:0]          x_ff, x_in;
   logic [SHW-1:0]         sh_ff, sh_in;
   logic [NDW-1:0]         norm_div;

   logic                   rv_ff;
   logic [STATUS_W-1:0]    r_st_ff;
   logic [VALUE_WIDTH-1:0] r_val_ff;
   logic [1:0]             r_lvl_ff;
   logic [6:0]             r_occ_ff;

   logic                   accept;
   assign req.ready = (state_ff == S_IDLE);
   assign accept = req.valid && req.ready;

   function automatic logic [PW-1:0] wrap(input logic [CW:0] a, input logic [CW-1:0] c);
      logic [CW:0] r;
      r = a;
      if (r >= {1'b0, c}) r = r - {1'b0, c};
      return PW'(r);
   endfunction

   // pop level search over the row
   logic           found;
   logic [LW-1:0]  flvl;
   always_comb begin
      found = 1'b0;
      flvl  = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (l < 32'(nlev) && desc_rd_ff[l].cnt != '0) begin
            found = 1'b1;
            flvl  = LW'(l);
         end
      end
   end

   desc_type dsel;
   assign dsel = desc_rd_ff[lvl_ff];

   // one restoring step of the ring index reduction per cycle
   assign norm_div = NDW'(cap) << sh_ff;

   logic [SAW-1:0] ring_base;
   assign ring_base = {q_ff, lvl_ff, {PW{1'b0}}};

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      lvl_in   = lvl_ff;
      cur_in   = cur_ff;
      k_in     = k_ff;
      u_in     = u_ff;
      nh_in    = nh_ff;
      st_in    = st_ff;
      pop_in   = pop_ff;
      x_in     = x_ff;
      sh_in    = sh_ff;
      d_we     = 1'b0;
      d_waddr  = q_ff;
      for (int l = 0; l < NUM_LEVELS; l++) d_wrow[l] = desc_rd_ff[l];
      d_raddr  = q_ff;
      s_we     = 1'b0;
      s_waddr  = ring_base;
      s_wdata  = val_ff;
      s_re     = 1'b0;
      s_raddr  = ring_base;
      unique case (state_ff)
         S_CLEAR: begin
            d_we    = 1'b1;
            d_waddr = clr_ff;
            for (int l = 0; l < NUM_LEVELS; l++) d_wrow[l] = '0;
            clr_in  = clr_ff + QW'(1);
            if (32'(clr_ff) == NUM_QUEUES - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            d_raddr = req.queue_id[QW-1:0];
            if (accept) state_in = S_READ;
         end
         S_READ: begin
            x_in = dsel.tail;
            if (func_ff == FUNC_POP) x_in = desc_rd_ff[flvl].head;
            else if (urg_ff) x_in = dsel.head;
            sh_in = SHW'(PW - 1);
            if ({1'b0, x_in} >= cap &&
                (func_ff == FUNC_PUSH || (func_ff == FUNC_POP && found)))
               state_in = S_NORM;
            else
               state_in = S_DECIDE;
         end
         S_NORM: begin
            if (NDW'(x_ff) >= norm_div) x_in = PW'(NDW'(x_ff) - norm_div);
            sh_in = sh_ff - SHW'(1);
            if (sh_ff == '0) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // descriptor row valid; store read for pop issued here
            cur_in = dsel;
            st_in  = ST_OK;
            pop_in = 1'b0;
            state_in = S_DONE;
            case (func_ff)
               FUNC_PUSH: begin
                  if (dsel.cnt >= cap) begin
                     st_in = ST_FULL;
                  end else if (urg_ff) begin
                     nh_in  = wrap({1'b0, CW'(x_ff)} + {1'b0, cap} - (CW+1)'(1), cap);
                     u_in   = (dsel.urg >= cap) ? cap - CW'(1) : dsel.urg;
                     k_in   = '0;
                     cur_in.head = x_ff;
                     state_in = S_SHIFT_RD;
                  end else begin
                     s_we    = 1'b1;
                     s_waddr = ring_base | SAW'(x_ff);
                     cur_in.tail = wrap({1'b0, CW'(x_ff)} + (CW+1)'(1), cap);
                     cur_in.cnt  = dsel.cnt + CW'(1);
                     d_we = 1'b1;
                     d_wrow[lvl_ff] = cur_in;
                  end
               end
               FUNC_POP: begin
                  if (!found) begin
                     st_in = ST_EMPTY;
                  end else begin
                     pop_in = 1'b1;
                     lvl_in = flvl;
                     cur_in = desc_rd_ff[flvl];
                     s_re    = 1'b1;
                     s_raddr = {q_ff, flvl, x_ff};
                     cur_in.head = wrap({1'b0, CW'(x_ff)} + (CW+1)'(1), cap);
                     cur_in.cnt = desc_rd_ff[flvl].cnt - CW'(1);
                     if (desc_rd_ff[flvl].urg != '0) cur_in.urg = desc_rd_ff[flvl].urg - CW'(1);
                     d_we = 1'b1;
                     d_wrow[flvl] = cur_in;
                  end
               end
               default: ;
            endcase
         end
         S_SHIFT_RD: begin
            if (k_ff == u_ff) begin
               s_we    = 1'b1;
               s_waddr = ring_base | SAW'(wrap({1'b0, CW'(nh_ff)} + {1'b0, u_ff}, cap));
               cur_in.head = nh_ff;
               cur_in.cnt  = cur_ff.cnt + CW'(1);
               cur_in.urg  = cur_ff.urg + CW'(1);
               d_we = 1'b1;
               for (int l = 0; l < NUM_LEVELS; l++) d_wrow[l] = desc_rd_ff[l];
               d_wrow[lvl_ff] = cur_in;
               state_in = S_DONE;
            end else begin
               s_re     = 1'b1;
               s_raddr  = ring_base | SAW'(wrap({1'b0, CW'(cur_ff.head)} + {1'b0, k_ff}, cap));
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            s_we    = 1'b1;
            s_waddr = ring_base | SAW'(wrap({1'b0, CW'(nh_ff)} + {1'b0, k_ff}, cap));
            s_wdata = store_rd_ff;
            k_in    = k_ff + CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_DONE: begin
            if (!rv_ff || rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req.func);
         q_ff    <= req.queue_id[QW-1:0];
         lvl_ff  <= LW'(32'(req.level) % NUM_LEVELS);
         urg_ff  <= req.urgent;
         val_ff  <= req.value;
      end else begin
         lvl_ff <= lvl_in;
      end
      cur_ff <= cur_in;
      k_ff   <= k_in;
      u_ff   <= u_in;
      nh_ff  <= nh_in;
      st_ff  <= st_in;
      pop_ff <= pop_in;
      x_ff   <= x_in;
      sh_ff  <= sh_in;
   end

   // response register
   logic [6:0] occ_c;
   always_comb begin
      occ_c = 7'(cur_ff.cnt);
      if (func_ff == FUNC_NONE || st_ff == ST_EMPTY) occ_c = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (state_ff == S_DONE && (!rv_ff || rsp.ready)) begin
         rv_ff <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
         rv_ff <= 1'b0;
      end
      if (state_ff == S_DONE && (!rv_ff || rsp.ready)) begin
         r_st_ff  <= st_ff;
         r_val_ff <= pop_ff ? store_rd_ff + VALUE_WIDTH'(hofs_ff) : '0;
         r_lvl_ff <= pop_ff ? 2'(lvl_ff) : 2'd0;
         r_occ_ff <= occ_c;
      end
   end

   assign rsp.valid        = rv_ff;
   assign rsp.status       = r_st_ff;
   assign rsp.value_out    = r_val_ff;
   assign rsp.served_level = r_lvl_ff;
   assign rsp.occupancy    = r_occ_ff;

endmodule

// ----- sv/prqm_checker.sv -----
// port-level checker for the priority ring queue manager, bound to the top level
module prqm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_served_level,
   input logic [31:0] rsp_value_out
);
   import prqm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value_out == '0 && rsp_served_level == '0)
      else $error("failed transaction carries data");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while busy");

endmodule

bind priority_ring_queue_manager_core prqm_checker u_prqm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_served_level(rsp.served_level),
   .rsp_value_out(rsp.value_out[31:0])
);

// ----- test/tb_top.sv -----
// self-checking testbench for the priority ring queue manager core
`timescale 1ns / 1ps

module tb_top;
   import prqm_pkg::*;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  queue_id;
      logic [1:0]  level;
      logic        urgent;
      logic [31:0] value;
   } request_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [1:0]  served_level;
      logic [6:0]  occupancy;
   } response_t;

   typedef struct {
      request_t  req;
      logic      has_rsp;
      response_t rsp;
   } stim_row_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   prqm_req_if req_ch ();
   prqm_rsp_if rsp_ch ();

   priority_ring_queue_manager_core dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow state of the queue rings
   logic [31:0] ring_mem [64][64];
   logic [5:0]  ring_head [64];
   logic [5:0]  ring_tail [64];
   logic [6:0]  ring_count [64];
   logic [6:0]  ring_urgent [64];
   logic [2:0]  levels_reg;
   logic [6:0]  cap_reg;
   logic [11:0] offset_reg;

   response_t pending_rsps [$];
   int mismatches = 0;
   int stall_rx = 0;
   int rx_idle = 0;
   bit rx_long_hold = 0;
   bit no_idle = 0;
   bit done = 0;
   int issued = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   function automatic response_t predict_queue_op(request_t r);
      response_t o;
      int cap, q, ring, h, nh, u, n;
      logic [31:0] v;
      o = '0;
      cap = (cap_reg < 1) ? 1 : (cap_reg > 64 ? 64 : cap_reg);
      q = r.queue_id;
      ring = q * 4 + r.level;
      case (func_type'(r.func))
         FUNC_PUSH: begin
            if (ring_count[ring] >= cap) begin
               o.status = ST_FULL;
               o.occupancy = ring_count[ring];
            end else begin
               if (r.urgent) begin
                  h = ring_head[ring] % cap;
                  nh = (h + cap - 1) % cap;
                  u = ring_urgent[ring];
                  if (u >= cap) u = cap - 1;
                  for (int k = 0; k < u; k++)
                     ring_mem[ring][(nh + k) % cap] = ring_mem[ring][(h + k) % cap];
                  ring_mem[ring][(nh + u) % cap] = r.value;
                  ring_head[ring] = nh;
                  ring_urgent[ring] = ring_urgent[ring] + 1;
               end else begin
                  h = ring_tail[ring] % cap;
                  ring_mem[ring][h] = r.value;
                  ring_tail[ring] = (h + 1) % cap;
               end
               ring_count[ring] = ring_count[ring] + 1;
               o.status = ST_OK;
               o.occupancy = ring_count[ring];
            end
         end
         FUNC_POP: begin
            n = levels_reg > 4 ? 4 : levels_reg;
            o.status = ST_EMPTY;
            for (int l = n - 1; l >= 0; l--) begin
               ring = q * 4 + l;
               if (ring_count[ring] > 0) begin
                  h = ring_head[ring] % cap;
                  v = ring_mem[ring][h];
                  ring_head[ring] = (h + 1) % cap;
                  ring_count[ring] = ring_count[ring] - 1;
                  if (ring_urgent[ring] > 0) ring_urgent[ring] = ring_urgent[ring] - 1;
                  o.status = ST_OK;
                  o.value_out = v + offset_reg;
                  o.served_level = l;
                  o.occupancy = ring_count[ring];
                  break;
               end
            end
         end
         FUNC_QUERY: o.occupancy = ring_count[ring];
         default: o = '0;
      endcase
      return o;
   endfunction

   task automatic write_reg(reg_type idx, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= 4 * idx;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_LEVELS: levels_reg = data[2:0];
         REG_CAP: cap_reg = data[6:0];
         default: offset_reg = data[11:0];
      endcase
   endtask

   task automatic drain_queue();
      req_ch.valid <= 0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // empty every ring so a capacity change never exposes unwritten slots
   task automatic flush_rings();
      request_t r;
      drain_queue();
      write_reg(REG_LEVELS, 4);
      for (int q = 0; q < 16; q++) begin
         while (ring_count[q*4] + ring_count[q*4+1] + ring_count[q*4+2]
                + ring_count[q*4+3] != 0) begin
            r = '0;
            r.func = FUNC_POP;
            r.queue_id = q;
            send_request(r, 0, '0);
         end
      end
      drain_queue();
   endtask

   task automatic send_request(request_t r, bit has_rsp, response_t exp_rsp);
      response_t p;
      if (!no_idle && $urandom_range(0, 9) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1;
      {req_ch.func, req_ch.queue_id, req_ch.level, req_ch.urgent, req_ch.value} <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      p = predict_queue_op(r);
      if (has_rsp && p != exp_rsp) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with prediction: table %h predicted %h",
                     exp_rsp, p);
      end
      pending_rsps.push_back(p);
      issued++;
   endtask

   function automatic request_t random_request(int qmax);
      request_t r;
      r.func = ($urandom_range(0, 19) == 0) ? FUNC_NONE : $urandom_range(0, 2);
      r.queue_id = $urandom_range(0, qmax);
      r.level = $urandom_range(0, 3);
      r.urgent = $urandom_range(0, 1);
      r.value = $urandom;
      if (r.func == FUNC_PUSH && $urandom_range(0, 1)) r.func = FUNC_PUSH;
      return r;
   endfunction

   // receiver with random stalls and one long hold-off
   initial begin
      response_t got, want;
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.status, rsp_ch.value_out, rsp_ch.served_level,
                   rsp_ch.occupancy};
            if (pending_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %h", got);
            end else begin
               want = pending_rsps.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         if (rx_long_hold) begin
            rsp_ch.ready <= 0;
            stall_rx++;
            if (stall_rx >= 300) rx_long_hold = 0;
         end else if (rx_idle > 0 && !no_idle) begin
            rsp_ch.ready <= 0;
            rx_idle--;
         end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            rsp_ch.ready <= 0;
            rx_idle = $urandom_range(0, 17);
         end else
            rsp_ch.ready <= 1;
      end
   end

   initial begin
      stim_row_t rows [$];
      stim_row_t row;
      request_t r;
      req_ch.valid = 0;
      req_ch.func = 0;
      req_ch.queue_id = 0;
      req_ch.level = 0;
      req_ch.urgent = 0;
      req_ch.value = 0;
      for (int i = 0; i < 64; i++) begin
         ring_head[i] = 0; ring_tail[i] = 0; ring_count[i] = 0; ring_urgent[i] = 0;
      end
      levels_reg = 1;
      cap_reg = 64;
      offset_reg = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed table: empty pop, extremes, urgent ordering, unused func
      rows.push_back('{'{FUNC_POP, 4'd0, 2'd0, 1'b0, 32'h0}, 1,
                       '{ST_EMPTY, 32'h0, 2'd0, 7'd0}});
      rows.push_back('{'{FUNC_QUERY, 4'd15, 2'd3, 1'b0, 32'h0}, 1, '{ST_OK, 0, 0, 0}});
      rows.push_back('{'{FUNC_PUSH, 4'd0, 2'd0, 1'b0, 32'hFFFFFFFF}, 1,
                       '{ST_OK, 0, 0, 7'd1}});
      rows.push_back('{'{FUNC_PUSH, 4'd0, 2'd0, 1'b1, 32'h11111111}, 0, '0});
      rows.push_back('{'{FUNC_PUSH, 4'd0, 2'd0, 1'b1, 32'h22222222}, 0, '0});
      rows.push_back('{'{FUNC_PUSH, 4'd0, 2'd0, 1'b0, 32'h0}, 0, '0});
      rows.push_back('{'{FUNC_PUSH, 4'd15, 2'd3, 1'b1, 32'hA5A5A5A5}, 1,
                       '{ST_OK, 0, 0, 7'd1}});
      rows.push_back('{'{FUNC_POP, 4'd15, 2'd0, 1'b0, 32'h0}, 1,
                       '{ST_EMPTY, 0, 0, 0}});
      rows.push_back('{'{FUNC_NONE, 4'd3, 2'd2, 1'b1, 32'hFFFFFFFF}, 1, '0});
      for (int i = 0; i < 5; i++)
         rows.push_back('{'{FUNC_POP, 4'd0, 2'd0, 1'b0, 32'h0}, 0, '0});
      rows.push_back('{'{FUNC_QUERY, 4'd0, 2'd0, 1'b0, 32'h0}, 1, '{ST_OK, 0, 0, 0}});
      foreach (rows[i]) send_request(rows[i].req, rows[i].has_rsp, rows[i].rsp);
      drain_queue();

      // every level in use, top offset, served level order
      write_reg(REG_LEVELS, 4);
      write_reg(REG_HOFS, 12'hFFF);
      for (int i = 0; i < 12; i++) begin
         r = random_request(15);
         r.func = (i < 8) ? FUNC_PUSH : FUNC_POP;
         r.queue_id = 5;
         send_request(r, 0, '0);
      end
      drain_queue();

      // receiver holds off while requests back up into the input
      rx_long_hold = 1;
      for (int i = 0; i < 20; i++) send_request(random_request(15), 0, '0);
      drain_queue();

      // small, zero and oversize capacities and level counts with full and urgent wrap
      flush_rings();
      write_reg(REG_CAP, 3);
      for (int i = 0; i < 250; i++) send_request(random_request(1), 0, '0);
      flush_rings();
      write_reg(REG_CAP, 1);
      for (int i = 0; i < 100; i++) send_request(random_request(1), 0, '0);
      flush_rings();
      write_reg(REG_CAP, 0);
      write_reg(REG_LEVELS, 0);
      for (int i = 0; i < 60; i++) send_request(random_request(1), 0, '0);
      flush_rings();
      write_reg(REG_CAP, 127);
      write_reg(REG_LEVELS, 7);
      write_reg(REG_HOFS, $urandom_range(0, 4095));
      for (int i = 0; i < 400; i++) send_request(random_request(3), 0, '0);
      flush_rings();
      write_reg(REG_CAP, 8);
      write_reg(REG_LEVELS, 2);
      for (int i = 0; i < 300; i++) begin
         if (i == 200) no_idle = 1;
         send_request(random_request(15), 0, '0);
      end

      drain_queue();
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
